@@ src/upd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared beat types, scanner states and hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] PctChar = 8'h25;

  // One input beat: a raw byte of the encoded string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  // One output beat: a decoded byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upd_out_t;

  // Work handed from the scanner to the serializer: one to three bytes,
  // left aligned, the last of which carries the end-of-string flag.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } upd_cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_e;

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30 : 8'h39], [8'h41 : 8'h46], [8'h61 : 8'h66]};
  endfunction

  // Valid only for hex digits: letters of either case share the low bits.
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] nib;
    if (c <= 8'h39) begin
      nib = c[3:0];
    end else begin
      nib = c[3:0] + 4'd9;
    end
    return nib;
  endfunction

endpackage
`default_nettype wire

@@ src/upd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder scanner
// Tracks escape state and turns each input beat into a byte group command.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire upd_in_t  in_data_i,
  output      logic     cmd_push_o,
  output      upd_cmd_t cmd_o
);

  upd_phase_e phase_q, phase_d;
  logic [7:0] held_q;
  logic [7:0] b;
  logic       last;
  logic       hv;
  logic       b_pct;

  assign b     = in_data_i.in_byte;
  assign last  = in_data_i.in_last;
  assign hv    = is_hex(b);
  assign b_pct = (b == PctChar);

  // Next state.
  always_comb begin
    phase_d = PH_IDLE;
    case (phase_q)
      PH_PCT: begin
        if (hv) begin
          phase_d = last ? PH_IDLE : PH_DIGIT;
        end else if (b_pct && !last) begin
          phase_d = PH_PCT;
        end
      end
      PH_DIGIT: begin
        if (!hv && b_pct && !last) begin
          phase_d = PH_PCT;
        end
      end
      default: begin
        if (b_pct && !last) begin
          phase_d = PH_PCT;
        end
      end
    endcase
  end

  // Outputs: the bytes this beat releases.
  always_comb begin
    cmd_o      = '0;
    cmd_o.last = last;
    case (phase_q)
      PH_PCT: begin
        if (hv) begin
          if (last) begin
            cmd_o.cnt      = 2'd2;
            cmd_o.bytes[0] = PctChar;
            cmd_o.bytes[1] = b;
          end
        end else begin
          cmd_o.bytes[0] = PctChar;
          if (b_pct && !last) begin
            cmd_o.cnt = 2'd1;
          end else begin
            cmd_o.cnt      = 2'd2;
            cmd_o.bytes[1] = b;
          end
        end
      end
      PH_DIGIT: begin
        if (hv && is_hex(held_q)) begin
          cmd_o.cnt      = 2'd1;
          cmd_o.bytes[0] = {hex_nibble(held_q), hex_nibble(b)};
        end else begin
          cmd_o.bytes[0] = PctChar;
          cmd_o.bytes[1] = held_q;
          if (b_pct && !last) begin
            cmd_o.cnt = 2'd2;
          end else begin
            cmd_o.cnt      = 2'd3;
            cmd_o.bytes[2] = b;
          end
        end
      end
      default: begin
        if (!(b_pct && !last)) begin
          cmd_o.cnt      = 2'd1;
          cmd_o.bytes[0] = b;
        end
      end
    endcase
  end

  assign cmd_push_o = accept_i && (cmd_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      if ((phase_q == PH_PCT) && hv) begin
        held_q <= b;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/upd_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder command queue
// Short register queue between scanner and serializer.
// ----------------------------------------------------------------------------
module upd_cmd_fifo import upd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire upd_cmd_t data_i,
  input  wire logic     pop_i,
  output      upd_cmd_t data_o,
  output      logic     valid_o,
  output      logic     full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  upd_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // The scanner only pushes when the queue has room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  // Fill level tracks the pointer distance.
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != FullCnt) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue fill count disagrees with pointers");

endmodule
`default_nettype wire

@@ src/upd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder serializer
// Emits the bytes of each queued command one beat at a time.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire upd_cmd_t cmd_i,
  input  wire logic     cmd_valid_i,
  output      logic     cmd_pop_o,
  input  wire logic     pop_i,
  output      logic     empty_o,
  output      upd_out_t out_data_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  upd_out_t   out_q;
  logic       can_load, load, at_end;

  assign can_load   = !out_valid_q || pop_i;
  assign load       = cmd_valid_i && can_load;
  assign at_end     = (idx_q == cmd_i.cnt - 2'd1);
  assign cmd_pop_o  = load && at_end;
  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= cmd_i.bytes[idx_q];
      out_q.out_last <= cmd_i.last && at_end;
    end
  end

  // The byte index never runs past the head command's byte count.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q < cmd_i.cnt))
    else $error("serializer index beyond command length");

  // A waiting output beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_q)))
    else $error("output beat changed while stalled");

endmodule
`default_nettype wire

@@ src/url_percent_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming percent-decoding of a byte string, one raw byte per beat.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------
//  input    in         push / full          in_data_i  {in_byte, in_last}
//  output   out        pop / empty          out_data_o {out_byte, out_last}
//
// A beat is taken every cycle in which push is high and full is low; the
// scanner works in the same cycle, so one byte per cycle is sustained
// while the queue has room. A failed escape releases up to three bytes,
// which the serializer emits at one byte per cycle while the output is
// popped; the command queue (FifoDepth entries) absorbs this. A result
// is held in the output register until popped. Reset clears all state.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output      logic     full,
  input  wire upd_in_t  in_data_i,
  output      logic     empty,
  input  wire logic     pop,
  output      upd_out_t out_data_o
);

  // Front side: the scanner sees every accepted beat and turns it into a
  // command of zero to three bytes; empty commands are dropped.
  logic     accept;
  logic     cmd_push;
  upd_cmd_t cmd_in;

  // Back side: the head command and its dequeue strobe.
  upd_cmd_t cmd_head;
  logic     cmd_valid;
  logic     cmd_pop;

  // The input stalls only when the command queue has no room, so a waiting
  // output beat never blocks acceptance by itself.
  assign accept = push && !full;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  upd_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid),
    .full_o  (full)
  );

  // The serializer walks each command byte by byte into the output register.
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ dv/tb_url_percent_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded byte strings through the push/full side and checks each
// decoded beat popped from the empty/pop side against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder;
  import upd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned QuietTail   = 60;
  localparam int unsigned RandomBeats = 450;
  localparam int unsigned HoldStart   = 120;
  localparam int unsigned HoldLength  = 150;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     push      = 1'b0;
  logic     pop       = 1'b0;
  upd_in_t  in_data_i = '0;
  logic     full;
  logic     empty;
  upd_out_t out_data_o;

  // Raw beats still to be offered, and decoded beats still to be popped.
  upd_in_t  pending_beats[$];
  upd_out_t expected_bytes[$];

  // Decoder state mirrored in the bench.
  upd_phase_e  scan_phase = PH_IDLE;
  logic [7:0]  held_digit = '0;

  int unsigned cycle_count  = 0;
  int unsigned beats_in     = 0;
  int unsigned bytes_out    = 0;
  int unsigned error_count  = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_cycles  = 0;
  logic        hold_done    = 1'b0;
  logic        in_accepted  = 1'b0;
  logic        quiet        = 1'b0;

  url_percent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Value of a hex digit of either case, or -1 for any other byte.
  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  task automatic expect_byte(logic [7:0] b, logic last);
    upd_out_t r;
    r.out_byte = b;
    r.out_last = last;
    expected_bytes.push_back(r);
  endtask

  // Scan a byte with no escape open. A '%' opens one unless the string ends
  // on it, in which case it goes out as is.
  task automatic scan_plain(logic [7:0] b, logic last);
    if (b == PctChar && !last) begin
      scan_phase = PH_PCT;
    end else begin
      expect_byte(b, last);
      scan_phase = PH_IDLE;
    end
  endtask

  // Work out the decoded beats that one accepted raw beat releases.
  task automatic decode_beat(upd_in_t beat);
    int lo;
    int hi;
    lo = hex_digit(beat.in_byte);
    hi = hex_digit(held_digit);
    case (scan_phase)
      PH_PCT: begin
        if (lo >= 0 && beat.in_last) begin
          // The string ends after the first digit: flush both unchanged.
          expect_byte(PctChar, 1'b0);
          expect_byte(beat.in_byte, 1'b1);
          scan_phase = PH_IDLE;
        end else if (lo >= 0) begin
          held_digit = beat.in_byte;
          scan_phase = PH_DIGIT;
        end else begin
          // Not a digit: the '%' passes and this byte is scanned afresh.
          expect_byte(PctChar, 1'b0);
          scan_plain(beat.in_byte, beat.in_last);
        end
      end
      PH_DIGIT: begin
        if (lo >= 0 && hi >= 0) begin
          expect_byte({hi[3:0], lo[3:0]}, beat.in_last);
          scan_phase = PH_IDLE;
        end else begin
          // Failed after one digit: up to three beats come out.
          expect_byte(PctChar, 1'b0);
          expect_byte(held_digit, 1'b0);
          scan_plain(beat.in_byte, beat.in_last);
        end
      end
      default: scan_plain(beat.in_byte, beat.in_last);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_beat(logic [7:0] b, logic last);
    upd_in_t beat;
    beat.in_byte = b;
    beat.in_last = last;
    pending_beats.push_back(beat);
  endtask

  // Queue a text string, with the end-of-string flag on its final byte.
  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_beat(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + v[7:0];
    if (v < 16) return 8'h61 + v[7:0] - 8'd10;
    return 8'h41 + v[7:0] - 8'd16;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: beats change on the falling edge. A beat is held until
  // the rising edge accepts it; only then may a gap or the next beat follow.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_input
    logic    offer;
    upd_in_t beat;
    offer = push;
    beat  = in_data_i;
    if (rst_ni && (!push || in_accepted)) begin
      offer = 1'b0;
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 10) - 1;
      end else if (pending_beats.size() != 0) begin
        beat  = pending_beats.pop_front();
        offer = 1'b1;
      end
    end
    push      <= offer;
    in_data_i <= beat;
    // The tail of the run goes at full rate on both sides.
    quiet     <= pending_beats.size() < QuietTail;
  end

  // --------------------------------------------------------------------------
  // Output side: random pop bursts, plus one long hold-off counted below.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_pop
    if (rst_ni) begin
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        pop      <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 10) - 1;
        pop      <= 1'b0;
      end else begin
        pop <= (hold_cycles == 0);
      end
    end
  end

  // Once enough beats have gone in, stop popping for a long stretch while the
  // sender keeps offering, so that the decoder backs up and raises full.
  always @(negedge clk_i) begin : long_hold
    if (rst_ni) begin
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && beats_in >= HoldStart) begin
        hold_cycles <= HoldLength;
        hold_done   <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks popped beats, then predicts from the accepted raw beat.
  // A beat accepted at this edge cannot already be on the output.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    upd_out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        bytes_out <= bytes_out + 1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                   $time, out_data_o.out_byte, out_data_o.out_last);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, out_data_o.out_byte);
            error_count++;
          end
          if (out_data_o.out_last !== want.out_last) begin
            $display("%0t: out_last expected %0b, got %0b",
                     $time, want.out_last, out_data_o.out_last);
            error_count++;
          end
        end
      end
      if (push && !full) begin
        decode_beat(in_data_i);
        beats_in <= beats_in + 1;
      end
      in_accepted <= push && !full;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_url_percent_decoder: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    int unsigned random_beats;
    int unsigned tokens;
    int unsigned kind;
    int unsigned before_len;
    logic [7:0]  body[$];

    // Directed strings: raw byte extremes before an escape, a decoded '%'
    // that is not scanned again, lower and upper case digits, a failed
    // escape after one digit, a failed escape whose next byte opens a new
    // one, escapes cut off by the end of the string, and a '%' before a non-digit.
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_text("%41");
    queue_text("%25%6a");
    queue_text("%4z");
    queue_text("%%41");
    queue_text("%");
    queue_text("%F");
    queue_text("%g");

    // Random strings built from tokens: mostly well-formed escapes and
    // plain bytes, with broken escapes mixed in.
    random_beats = 0;
    while (random_beats < RandomBeats) begin
      tokens = $urandom_range(1, 5);
      body.delete();
      for (int t = 0; t < tokens; t++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          body.push_back(PctChar);
          body.push_back(rand_hex_char());
          body.push_back(rand_hex_char());
        end else if (kind < 8) begin
          body.push_back(8'($urandom_range(0, 255)));
        end else begin
          body.push_back(PctChar);
          if ($urandom_range(0, 1) == 1) body.push_back(rand_hex_char());
        end
      end
      before_len = body.size();
      for (int i = 0; i < before_len; i++) begin
        queue_beat(body[i], i == before_len - 1);
      end
      random_beats += before_len;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every raw beat taken, every decoded beat popped, then a short drain
    // so that a stray extra beat would still be caught.
    while (pending_beats.size() != 0 || push) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d raw beats in encoded strings and checked %0d decoded beats,",
             beats_in, bytes_out);
    $display("with random stalls on both sides and one long output hold-off.");
    if (error_count == 0) begin
      $display("tb_url_percent_decoder: clean");
    end else begin
      $display("tb_url_percent_decoder: errors");
    end
    $finish;
  end

endmodule
